### sv/bldc_zc_pkg.sv
package bldc_zc_pkg;

    // Field widths
    localparam int unsigned STEP_W  = 3;
    localparam int unsigned CNT_W   = 18;
    localparam int unsigned TOTAL_W = 16;
    localparam int unsigned HIST_W  = 8;
    localparam int unsigned THR_W   = 4;
    localparam int unsigned ONES_W  = 4;

    // Period arithmetic: sum = 2*count + 99*reload fits in 25 bits
    localparam int unsigned SUM_W       = 25;
    localparam int unsigned RECIP_W     = 26;
    localparam int unsigned RECIP_SHIFT = 32;
    localparam int unsigned PROD_W      = SUM_W + RECIP_W;
    localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;

    // ceil(2^32 / 100): exact floor(sum / 100) for every sum below 2^30
    localparam logic [RECIP_W-1:0] RECIP_MUL = 26'd42949673;
    localparam logic [6:0]         MUL_99    = 7'd99;

    localparam logic [CNT_W-1:0]   RELOAD_MAX = 18'h3FFFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 16'hFFFF;
    localparam logic [STEP_W-1:0]  STEP_FIRST = 3'd0;
    localparam logic [STEP_W-1:0]  STEP_LAST  = 3'd5;

    // Action codes
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_COMMUT = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_LOAD   = 2'd3;

    // Motor mode codes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_OPEN = 2'd1;
    localparam logic [1:0] MODE_RUN  = 2'd2;

    // Phase drive codes
    localparam logic [1:0] DRV_PWM  = 2'd0;
    localparam logic [1:0] DRV_HIGH = 2'd1;
    localparam logic [1:0] DRV_LOW  = 2'd2;

    // Configuration register byte addresses
    localparam logic [1:0] ADDR_ZC_THRESHOLD = 2'd0;
    localparam logic [THR_W-1:0] ZC_THRESHOLD_RST = 4'd5;

    typedef struct packed {
        logic [1:0]        action;
        logic [2:0]        bemf;       // {w, v, u}
        logic [1:0]        mode;
        logic [SUM_W-1:0]  sum;
        logic [STEP_W-1:0] step_value;
    } t_item;

    typedef struct packed {
        logic [1:0] u;
        logic [1:0] v;
        logic [1:0] w;
    } t_drive;

    typedef struct packed {
        t_drive             drive;
        logic [STEP_W-1:0]  step;
        logic               zc_detected;
        logic [TOTAL_W-1:0] count;
        logic [CNT_W-1:0]   new_reload;
        logic               reload_update;
    } t_result;

    // Drive pattern of one commutation step
    function automatic t_drive drive_of(input logic [STEP_W-1:0] step);
        t_drive d;
        case (step)
            3'd0:    d = '{u: DRV_PWM,  v: DRV_HIGH, w: DRV_LOW };
            3'd1:    d = '{u: DRV_PWM,  v: DRV_LOW,  w: DRV_HIGH};
            3'd2:    d = '{u: DRV_LOW,  v: DRV_PWM,  w: DRV_HIGH};
            3'd3:    d = '{u: DRV_HIGH, v: DRV_PWM,  w: DRV_LOW };
            3'd4:    d = '{u: DRV_HIGH, v: DRV_LOW,  w: DRV_PWM };
            3'd5:    d = '{u: DRV_LOW,  v: DRV_HIGH, w: DRV_PWM };
            default: d = '{u: DRV_PWM,  v: DRV_HIGH, w: DRV_LOW };
        endcase
        return d;
    endfunction

    // Comparator bit of the floating phase, inverted on odd steps
    function automatic logic float_bit(input logic [STEP_W-1:0] step, input logic [2:0] bemf);
        logic b;
        case (step)
            3'd0:    b = bemf[0];
            3'd1:    b = ~bemf[2];
            3'd2:    b = bemf[1];
            3'd3:    b = ~bemf[0];
            3'd4:    b = bemf[2];
            3'd5:    b = ~bemf[1];
            default: b = bemf[0];
        endcase
        return b;
    endfunction

    function automatic logic [ONES_W-1:0] ones8(input logic [HIST_W-1:0] v);
        logic [ONES_W-1:0] n;
        n = '0;
        for (int i = 0; i < HIST_W; i++) begin
            n = n + ONES_W'(v[i]);
        end
        return n;
    endfunction

endpackage

### sv/bldc_zc_period.sv
module bldc_zc_period (
    input  logic [bldc_zc_pkg::SUM_W-1:0] i_sum,
    output logic [bldc_zc_pkg::CNT_W-1:0] o_reload
);
    import bldc_zc_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;

    // Divide by 100 through the scaled reciprocal
    assign prod = PROD_W'(i_sum) * PROD_W'(RECIP_MUL);
    assign quot = prod[PROD_W-1:RECIP_SHIFT];

    // Clamp to the timer range
    assign o_reload = (quot > QUOT_W'(RELOAD_MAX)) ? RELOAD_MAX : quot[CNT_W-1:0];

endmodule

### sv/bldc_zc_core.sv
module bldc_zc_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  bldc_zc_pkg::t_item              i_item,
    input  logic [bldc_zc_pkg::THR_W-1:0]   i_threshold,
    input  logic [bldc_zc_pkg::CNT_W-1:0]   i_reload,
    output bldc_zc_pkg::t_result            o_result
);
    import bldc_zc_pkg::*;

    logic [STEP_W-1:0]  r_step,  n_step;
    logic [HIST_W-1:0]  r_hist,  n_hist;
    logic               r_seen,  n_seen;
    logic [TOTAL_W-1:0] r_total, n_total;

    logic [HIST_W-1:0]  hist_shift;
    logic               detected;
    logic               update;
    logic [CNT_W-1:0]   new_reload;
    logic [TOTAL_W-1:0] count_out;

    assign hist_shift = {r_hist[HIST_W-2:0], float_bit(r_step, i_item.bemf)};

    // Work out the next state for the beat in the input stage
    always_comb begin
        n_step     = r_step;
        n_hist     = r_hist;
        n_seen     = r_seen;
        n_total    = r_total;
        detected   = 1'b0;
        update     = 1'b0;
        new_reload = '0;
        case (i_item.action)
            ACT_SAMPLE: begin
                if (!r_seen) begin
                    n_hist = hist_shift;
                    if (ones8(hist_shift) >= i_threshold) begin
                        n_seen   = 1'b1;
                        detected = 1'b1;
                        if (r_total != TOTAL_MAX) begin
                            n_total = r_total + 1'b1;
                        end
                        if (i_item.mode == MODE_RUN) begin
                            update     = 1'b1;
                            new_reload = i_reload;
                        end
                    end
                end
            end
            ACT_COMMUT: begin
                if (i_item.mode inside {MODE_OPEN, MODE_RUN}) begin
                    n_step = (r_step == STEP_LAST) ? STEP_FIRST : r_step + 1'b1;
                end
                n_hist = '0;
                n_seen = 1'b0;
            end
            ACT_READ: begin
                n_total = '0;
            end
            ACT_LOAD: begin
                if (i_item.step_value <= STEP_LAST) begin
                    n_step = i_item.step_value;
                end
            end
            default: begin
                n_step = r_step;
            end
        endcase
        count_out = (i_item.action == ACT_READ) ? r_total : n_total;
    end

    // Assemble the result beat
    always_comb begin
        o_result.drive         = drive_of(n_step);
        o_result.step          = n_step;
        o_result.zc_detected   = detected;
        o_result.count         = count_out;
        o_result.new_reload    = new_reload;
        o_result.reload_update = update;
    end

    // Commit state when the beat moves to the output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_FIRST;
            r_hist  <= '0;
            r_seen  <= 1'b0;
            r_total <= '0;
        end else if (i_adv) begin
            r_step  <= n_step;
            r_hist  <= n_hist;
            r_seen  <= n_seen;
            r_total <= n_total;
        end
    end

endmodule

### sv/bldc_zc_top.sv
// Sensorless six-step BLDC commutation with back-EMF zero-crossing detection.
// Each accepted beat carries one action (sample, commutation, read-and-clear
// count, load step) and produces exactly one result beat with the phase
// drives for the step after that action, the zero-crossing flag, the
// crossing count and, on a crossing in running mode, the new commutation
// period floor((2*count + 99*reload) / 100), clamped to 18 bits.
// The block takes one beat per clock cycle while o_stall is low; an accepted
// beat passes the input register, then the result register, and the core
// state commits when the beat enters the result register. The zero-
// crossing threshold sits at APB byte address 0 and resets to 5; write it
// only while no beat is in flight.
module bldc_six_step_bemf_zero_cross_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // APB configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [1:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,

    // Input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [1:0]                           i_action,
    input  logic                                 i_bemf_u,
    input  logic                                 i_bemf_v,
    input  logic                                 i_bemf_w,
    input  logic [1:0]                           i_motor_mode,
    input  logic [bldc_zc_pkg::CNT_W-1:0]        i_commut_count,
    input  logic [bldc_zc_pkg::CNT_W-1:0]        i_commut_reload,
    input  logic [bldc_zc_pkg::STEP_W-1:0]       i_step_value,

    // Output channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [1:0]                           o_drive_u,
    output logic [1:0]                           o_drive_v,
    output logic [1:0]                           o_drive_w,
    output logic [bldc_zc_pkg::STEP_W-1:0]       o_current_step,
    output logic                                 o_zc_detected,
    output logic [bldc_zc_pkg::TOTAL_W-1:0]      o_crossing_count,
    output logic [bldc_zc_pkg::CNT_W-1:0]        o_new_reload,
    output logic                                 o_reload_update
);
    import bldc_zc_pkg::*;

    logic [THR_W-1:0] r_threshold;
    logic             cfg_wr;

    logic             r_s1_valid;
    t_item            r_s1_item;
    t_item            in_item;
    logic             s1_adv;
    logic             in_take;

    logic             r_out_valid;
    t_result          r_out;
    t_result          core_result;
    logic [CNT_W-1:0] period;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_ZC_THRESHOLD);
    assign prdata = (paddr == ADDR_ZC_THRESHOLD) ? {28'd0, r_threshold} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= ZC_THRESHOLD_RST;
        end else if (cfg_wr) begin
            r_threshold <= pwdata[THR_W-1:0];
        end
    end

    // Handshake: advance the input stage whenever the result register frees up
    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign in_take = i_valid && !o_stall;

    // Pack the incoming beat; fold the period numerator ahead of the register
    always_comb begin
        in_item.action     = i_action;
        in_item.bemf       = {i_bemf_w, i_bemf_v, i_bemf_u};
        in_item.mode       = i_motor_mode;
        in_item.sum        = (SUM_W'(i_commut_count) << 1)
                           + SUM_W'(i_commut_reload) * SUM_W'(MUL_99);
        in_item.step_value = i_step_value;
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item <= in_item;
        end
    end

    bldc_zc_period u_period (
        .i_sum    (r_s1_item.sum),
        .o_reload (period)
    );

    bldc_zc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (s1_adv),
        .i_item      (r_s1_item),
        .i_threshold (r_threshold),
        .i_reload    (period),
        .o_result    (core_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= core_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_drive_u        = r_out.drive.u;
    assign o_drive_v        = r_out.drive.v;
    assign o_drive_w        = r_out.drive.w;
    assign o_current_step   = r_out.step;
    assign o_zc_detected    = r_out.zc_detected;
    assign o_crossing_count = r_out.count;
    assign o_new_reload     = r_out.new_reload;
    assign o_reload_update  = r_out.reload_update;

endmodule
